/* rtl/gsd_pkg.sv */
// ----------------------------------------------------------------------------
// gsd_pkg: shared types and constants of the gyro stillness detector
// Sample and result item types, configuration register map and widths.
// ----------------------------------------------------------------------------
package gsd_pkg;

	// sample width per axis, two's complement
	localparam int RATE_WIDTH = 16;

	// register widths
	localparam int THR_W = 16;
	localparam int CNT_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;

	// width of the magnitude compare: exact difference or threshold, whichever is wider
	localparam int CMP_W = (RATE_WIDTH + 1 > THR_W) ? RATE_WIDTH + 1 : THR_W;

	// reset values of the registers
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);
	localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(30);
	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(10);
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANGE_THRESHOLD = 2'd0,
		CFG_WINDOW_LENGTH = 2'd1,
		CFG_JITTER_LIMIT = 2'd2
	} cfg_index_t;

	typedef logic signed [RATE_WIDTH-1:0] rate_t;

	typedef struct packed {
		rate_t rate_x;
		rate_t rate_y;
		rate_t rate_z;
	} sample_t;

	typedef struct packed {
		logic motion_state;
		logic decision_made;
	} result_t;

	typedef struct packed {
		logic [THR_W-1:0] change_threshold;
		logic [CNT_W-1:0] window_length;
		logic [CNT_W-1:0] jitter_limit;
	} cfg_t;

endpackage

/* rtl/gsd_lane.sv */
// ----------------------------------------------------------------------------
// gsd_lane: per-axis change detector
// Holds the previous sample of one axis and flags a change whose magnitude
// exceeds the threshold.
// ----------------------------------------------------------------------------
module gsd_lane
	import gsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rate_t            sample,
	input  logic [THR_W-1:0] threshold,
	output logic             jitter
);

	rate_t prev_q;
	logic signed [RATE_WIDTH:0] diff;
	logic [RATE_WIDTH:0] mag;
	logic [CMP_W-1:0] mag_ext;
	logic [CMP_W-1:0] thr_ext;

	// previous sample, stored on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (load) begin
			prev_q <= sample;
		end
	end

	// exact difference and its magnitude, one bit wider than the sample
	always_comb begin
		diff = $signed({sample[RATE_WIDTH-1], sample}) - $signed({prev_q[RATE_WIDTH-1], prev_q});
		mag = diff[RATE_WIDTH] ? $unsigned(-diff) : $unsigned(diff);
		mag_ext = CMP_W'(mag);
		thr_ext = CMP_W'(threshold);
	end

	assign jitter = mag_ext > thr_ext;

endmodule

/* rtl/gsd_window.sv */
// ----------------------------------------------------------------------------
// gsd_window: window counter and decision
// Merges the lane flags, counts jitter over a window and decides
// static or moving when the window is full.
// ----------------------------------------------------------------------------
module gsd_window
	import gsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [2:0] lane_jitter,
	input  cfg_t       cfg,
	output result_t    result
);

	logic [CNT_W-1:0] window_q;
	logic [CNT_W-1:0] jitter_q;
	logic moving_q;
	logic any_jitter;
	logic window_open;
	logic moving_next;

	// merge of the lanes
	assign any_jitter = |lane_jitter;
	assign window_open = window_q < cfg.window_length;

	// decision for the current item
	always_comb begin
		moving_next = moving_q;
		if (!window_open) begin
			moving_next = jitter_q > cfg.jitter_limit;
		end
		result.motion_state = moving_next;
		result.decision_made = !window_open;
	end

	// counters and placement flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			jitter_q <= '0;
			moving_q <= 1'b0;
		end else if (step) begin
			moving_q <= moving_next;
			if (window_open) begin
				window_q <= window_q + CNT_W'(1);
				if (any_jitter && jitter_q != CNT_MAX) begin
					jitter_q <= jitter_q + CNT_W'(1);
				end
			end else begin
				window_q <= '0;
				jitter_q <= '0;
			end
		end
	end

endmodule

/* rtl/gyro_stillness_detector_core.sv */
// ----------------------------------------------------------------------------
// gyro_stillness_detector_core: three-axis stillness detector
// Output: a result item is valid in the cycle after its sample item is taken.
// Throughput: one item per cycle while out_ready is high; the window and jitter
// counters update once per accepted item, and the output register frees in the cycle it is taken.
// Reset (arst_n, asynchronous): previous samples and counters cleared, state
// static, registers back to threshold 100, window 30, limit 10.
// ----------------------------------------------------------------------------
module gyro_stillness_detector_core
	import gsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sample_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic accept;
	logic [2:0] lane_jitter;
	result_t result;
	result_t out_data_q;
	logic out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.change_threshold <= THR_RESET;
			cfg_q.window_length <= WIN_RESET;
			cfg_q.jitter_limit <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHANGE_THRESHOLD: cfg_q.change_threshold <= cfg_data[THR_W-1:0];
				CFG_WINDOW_LENGTH:    cfg_q.window_length <= cfg_data[CNT_W-1:0];
				CFG_JITTER_LIMIT:     cfg_q.jitter_limit <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// take an item whenever the output slot is free or being emptied
	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	// one lane per axis
	gsd_lane u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.sample    (in_data.rate_x),
		.threshold (cfg_q.change_threshold),
		.jitter    (lane_jitter[0])
	);

	gsd_lane u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.sample    (in_data.rate_y),
		.threshold (cfg_q.change_threshold),
		.jitter    (lane_jitter[1])
	);

	gsd_lane u_lane_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.sample    (in_data.rate_z),
		.threshold (cfg_q.change_threshold),
		.jitter    (lane_jitter[2])
	);

	// merge and decide
	gsd_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.lane_jitter (lane_jitter),
		.cfg         (cfg_q),
		.result      (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

/* rtl/gsd_checker.sv */
// ----------------------------------------------------------------------------
// gsd_checker: port-level checks of the stillness detector
// Watches the handshakes and the placement reported between decisions.
// ----------------------------------------------------------------------------
module gsd_checker
	import gsd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input result_t               out_data
);

	logic last_state_q;

	// placement of the last delivered item, static after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_state_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			last_state_q <= out_data.motion_state;
		end
	end

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result item changed");

	// ready exactly when the output slot is free or draining
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output slot");

	// every accepted item yields a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item gave no result");

	// placement only changes on a deciding item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.decision_made |-> out_data.motion_state == last_state_q)
		else $error("placement changed without a decision");

endmodule

bind gyro_stillness_detector_core gsd_checker u_gsd_checker (.*);
